>>> src/descriptor_checksum_checker_top_macros.svh
// ----------------------------------------------------------------------------
// Descriptor checksum checker assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_CHECKSUM_CHECKER_TOP_MACROS_SVH
`define DESCRIPTOR_CHECKSUM_CHECKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCC_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/dcc_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor checksum checker package
// Widths, codes, charset tables and polymod helpers shared by the checker.
// ----------------------------------------------------------------------------
package dcc_pkg;

   // Field widths.
   localparam int POLY_W       = 40;
   localparam int SYM_W        = 5;
   localparam int BYTE_W       = 8;
   localparam int POS_W        = 7;
   localparam int CHECK_LEN    = 8;
   localparam int EXPECT_W     = CHECK_LEN * BYTE_W;
   localparam int NUM_GEN      = 5;
   localparam int CHARSET_LEN  = 95;
   localparam int OUT_SYMBOLS  = 32;
   localparam int COUNT_W      = 2;
   localparam int ZERO_ROUNDS  = 8;

   // Word commands.
   localparam logic CMD_FEED   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   typedef logic [POLY_W-1:0]                    poly_type;
   typedef logic [SYM_W-1:0]                     sym_type;
   typedef logic [POLY_W-1:0][POLY_W-1:0]        poly_matrix_type;
   typedef logic [CHARSET_LEN-1:0][BYTE_W-1:0]   in_charset_type;
   typedef logic [OUT_SYMBOLS-1:0][BYTE_W-1:0]   out_charset_type;
   typedef logic [255:0][POS_W:0]                pos_table_type;

   // BCH generators, one per bit of the top symbol.
   localparam poly_type GEN [NUM_GEN] = '{
      40'hf5dee51989, 40'ha9fdca3312, 40'h1bab10e32d, 40'h3706b1677a, 40'h644d626ffd
   };

   // Input charset; the first character sits in the top element.
   localparam in_charset_type IN_CHARSET = {
      "0123456789()[],'/*abcdefgh@:$%{}IJKLMNOPQRSTUVWXYZ&+-.;<=>?!^_|~",
      "ijklmnopqrstuvwxyzABCDEFGH", 8'h60, "#", 8'h22, 8'h5c, " "
   };

   // Checksum charset; the character of symbol s is element 31 - s.
   localparam out_charset_type OUT_CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   // One polymod round: shift in a symbol and fold the top symbol back in.
   function automatic poly_type poly_round(poly_type acc, sym_type sym);
      poly_type r;
      r = {acc[POLY_W-SYM_W-1:0], {SYM_W{1'b0}}} ^ {{(POLY_W-SYM_W){1'b0}}, sym};
      for (int k = 0; k < NUM_GEN; k++) begin
         if (acc[POLY_W-SYM_W+k]) begin
            r = r ^ GEN[k];
         end
      end
      return r;
   endfunction

   // Columns of the linear map made by eight zero rounds.
   function automatic poly_matrix_type build_zero_rounds();
      poly_matrix_type m;
      poly_type        v;
      m = '0;
      for (int j = 0; j < POLY_W; j++) begin
         v = poly_type'(1) << j;
         for (int r = 0; r < ZERO_ROUNDS; r++) begin
            v = poly_round(v, '0);
         end
         m[j] = v;
      end
      return m;
   endfunction

   localparam poly_matrix_type ZERO_ROUNDS_MAP = build_zero_rounds();

   // Apply the eight zero rounds as one XOR network.
   function automatic poly_type apply_zero_rounds(poly_type acc);
      poly_type r;
      r = '0;
      for (int j = 0; j < POLY_W; j++) begin
         if (acc[j]) begin
            r = r ^ ZERO_ROUNDS_MAP[j];
         end
      end
      return r;
   endfunction

   // Byte to {valid, charset position}; bytes outside the charset read as invalid.
   function automatic pos_table_type build_pos_table();
      pos_table_type t;
      t = '0;
      for (int k = 0; k < CHARSET_LEN; k++) begin
         t[IN_CHARSET[CHARSET_LEN-1-k]] = {1'b1, POS_W'(k)};
      end
      return t;
   endfunction

   localparam pos_table_type POS_TABLE = build_pos_table();

endpackage

>>> src/dcc_req_if.sv
// ----------------------------------------------------------------------------
// Descriptor checksum request channel
// Valid/ready channel carrying one text byte or one finish word.
// ----------------------------------------------------------------------------
interface dcc_req_if
   import dcc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [BYTE_W-1:0]   text_byte;
   logic [EXPECT_W-1:0] expected_checksum;

   modport source (output valid, cmd, text_byte, expected_checksum, input ready);
   modport sink   (input valid, cmd, text_byte, expected_checksum, output ready);
endinterface

>>> src/dcc_rsp_if.sv
// ----------------------------------------------------------------------------
// Descriptor checksum response channel
// Valid/ready channel carrying the computed checksum and the verdict.
// ----------------------------------------------------------------------------
interface dcc_rsp_if
   import dcc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [POLY_W-1:0] checksum_symbols;
   logic              bad_character;
   logic              checksum_matches;

   modport source (output valid, checksum_symbols, bad_character, checksum_matches,
                   input ready);
   modport sink   (input valid, checksum_symbols, bad_character, checksum_matches,
                   output ready);
endinterface

>>> src/descriptor_checksum_checker_top.sv
// ----------------------------------------------------------------------------
// Descriptor checksum checker
//
//   Channel    Dir   Word                                      Result
//   req_chan   in    cmd, text_byte, expected_checksum         one per finish
//   rsp_chan   out   checksum_symbols, bad_character, matches  none per byte
//
// One word is taken per cycle, bytes and finish words alike, while the input
// register is free or moving on. In the input register a byte updates the
// polymod state with at most two rounds. A finish word then passes through the
// flush stage to the output register. A stalled response backs up through the
// flush stage only; bytes keep flowing until a finish word finds the flush
// stage full. Reset is synchronous and clears all control state.
// ----------------------------------------------------------------------------
module descriptor_checksum_checker_top
   import dcc_pkg::*;
(
   input logic      clock,
   input logic      reset,
   dcc_req_if.sink  req_chan,
   dcc_rsp_if.source rsp_chan
);

   `include "descriptor_checksum_checker_top_macros.svh"

   // Input register.
   logic                s1_valid_ff;
   logic                s1_cmd_ff;
   logic [BYTE_W-1:0]   s1_byte_ff;
   logic [EXPECT_W-1:0] s1_expected_ff;

   // Running checksum state.
   poly_type            acc_ff,   acc_in;
   sym_type             group_ff, group_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                error_ff, error_in;

   // Flush stage.
   logic                s2_valid_ff;
   poly_type            s2_acc_ff,      s2_acc_in;
   logic                s2_error_ff;
   logic [EXPECT_W-1:0] s2_expected_ff;

   // Output register.
   logic                s3_valid_ff;
   poly_type            s3_sum_ff,      s3_sum_in;
   logic                s3_bad_ff;
   logic                s3_match_ff,    s3_match_in;

   logic                s3_free;
   logic                s2_go;
   logic                s2_free;
   logic                s1_go;
   logic                req_take;
   logic [POS_W:0]      lookup;
   poly_type            acc_one;
   sym_type             group_next;
   logic                finish_go;
   logic                state_idle;

   // Flow control: each stage moves when the one after it has room; a byte leaves the input register without waiting.
   assign s3_free  = !s3_valid_ff || rsp_chan.ready;
   assign s2_go    = s2_valid_ff && s3_free;
   assign s2_free  = !s2_valid_ff || s2_go;
   assign s1_go    = s1_valid_ff && ((s1_cmd_ff == CMD_FEED) || s2_free);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || s1_go;

   // Byte update and finish flush from the input register.
   always_comb begin
      lookup     = POS_TABLE[s1_byte_ff];
      acc_one    = poly_round(acc_ff, lookup[SYM_W-1:0]);
      group_next = sym_type'(group_ff * 5'd3 + {3'b000, lookup[POS_W-1:SYM_W]});
      acc_in     = acc_ff;
      group_in   = group_ff;
      count_in   = count_ff;
      error_in   = error_ff;
      s2_acc_in  = (count_ff != '0) ? poly_round(acc_ff, group_ff) : acc_ff;
      if (s1_go) begin
         if (s1_cmd_ff == CMD_FINISH) begin
            acc_in   = poly_type'(1);
            group_in = '0;
            count_in = '0;
            error_in = 1'b0;
         end else if (!lookup[POS_W]) begin
            error_in = 1'b1;
         end else if (count_ff == 2'd2) begin
            acc_in   = poly_round(acc_one, group_next);
            group_in = '0;
            count_in = '0;
         end else begin
            acc_in   = acc_one;
            group_in = group_next;
            count_in = count_ff + 2'd1;
         end
      end
   end

   // Zero rounds, final constant and character compare from the flush stage.
   always_comb begin
      s3_sum_in   = apply_zero_rounds(s2_acc_ff) ^ poly_type'(1);
      s3_match_in = !s2_error_ff;
      for (int k = 0; k < CHECK_LEN; k++) begin
         if (s2_expected_ff[(CHECK_LEN-1-k)*BYTE_W +: BYTE_W] !=
             OUT_CHARSET[~s3_sum_in[(CHECK_LEN-1-k)*SYM_W +: SYM_W]]) begin
            s3_match_in = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         acc_ff      <= poly_type'(1);
         group_ff    <= '0;
         count_ff    <= '0;
         error_ff    <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_go && (s1_cmd_ff == CMD_FINISH);
         end
         if (s3_free) begin
            s3_valid_ff <= s2_go;
         end
         acc_ff   <= acc_in;
         group_ff <= group_in;
         count_ff <= count_in;
         error_ff <= error_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff      <= req_chan.cmd;
         s1_byte_ff     <= req_chan.text_byte;
         s1_expected_ff <= req_chan.expected_checksum;
      end
      if (s1_go && (s1_cmd_ff == CMD_FINISH)) begin
         s2_acc_ff      <= s2_acc_in;
         s2_error_ff    <= error_ff;
         s2_expected_ff <= s1_expected_ff;
      end
      if (s2_go) begin
         s3_sum_ff   <= s3_sum_in;
         s3_bad_ff   <= s2_error_ff;
         s3_match_ff <= s3_match_in;
      end
   end

   assign rsp_chan.valid            = s3_valid_ff;
   assign rsp_chan.checksum_symbols = s3_sum_ff;
   assign rsp_chan.bad_character    = s3_bad_ff;
   assign rsp_chan.checksum_matches = s3_match_ff;

   // Terms used by the checks below.
   assign finish_go  = s1_go && (s1_cmd_ff == CMD_FINISH);
   assign state_idle = (acc_ff == poly_type'(1)) && (group_ff == '0) && (count_ff == '0)
                       && !error_ff;

   // A finish word leaves the running state at its reset value.
   `DCC_ASSERT_NEXT(a_finish_clears, finish_go, state_idle, "state not cleared after finish")
   // An empty group holds no partial symbol.
   `DCC_ASSERT_NOW(a_empty_group, count_ff == '0, group_ff == '0, "partial symbol with empty group")
   // A bad character never passes the check.
   `DCC_ASSERT_NOW(a_bad_never_matches, s3_valid_ff && s3_bad_ff, !s3_match_ff, "match reported with bad character")

endmodule

>>> tb/dcc_checksum_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor checksum monitor
// Watches both channels of the checksum checker and follows the text stream
// with its own polymod state. Each accepted finish word queues the verdict the
// block should give, and each accepted response is compared with the oldest
// one, field by field. The running failure count is handed to the top.
// ----------------------------------------------------------------------------
module dcc_checksum_monitor
   import dcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_text_byte,
   input  logic [63:0] req_expected,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [39:0] rsp_checksum_symbols,
   input  logic        rsp_bad_character,
   input  logic        rsp_checksum_matches,
   output logic [63:0] current_chars,
   output int          results_owed,
   output int          fail_count,
   output int          checksums_seen,
   output int          matches_seen,
   output int          bad_seen
);

   typedef struct packed {
      logic [39:0] symbols;
      logic        bad;
      logic        ok;
   } verdict_type;

   // Text charset, first character in the top byte: all of printable ASCII.
   localparam logic [95*8-1:0] TEXT_ALPHABET = {
      "0123456789()[],'/*abcdefgh@:$%{}IJKLMNOPQRSTUVWXYZ&+-.;<=>?!^_|~",
      "ijklmnopqrstuvwxyzABCDEFGH", 8'h60, "#", 8'h22, 8'h5c, " "
   };

   // Checksum charset; symbol s sits in byte 31 - s.
   localparam logic [32*8-1:0] CHECK_ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   verdict_type pending_verdicts[$];
   logic [39:0] text_poly;
   logic [4:0]  text_group;
   logic [1:0]  text_count;
   logic        text_bad;

   // One BCH round: shift a symbol in and fold the top symbol back in.
   function automatic logic [39:0] mix_symbol(input logic [39:0] acc, input logic [4:0] sym);
      logic [39:0] r;
      logic [4:0]  top;
      top = acc[39:35];
      r = {acc[34:0], sym};
      if (top[0]) r = r ^ 40'hf5dee51989;
      if (top[1]) r = r ^ 40'ha9fdca3312;
      if (top[2]) r = r ^ 40'h1bab10e32d;
      if (top[3]) r = r ^ 40'h3706b1677a;
      if (top[4]) r = r ^ 40'h644d626ffd;
      return r;
   endfunction

   // Position of a byte in the text charset, or -1 when it is not there.
   function automatic int charset_index(input logic [7:0] b);
      for (int k = 0; k < 95; k++) begin
         if (TEXT_ALPHABET[8*(94-k) +: 8] == b) begin
            return k;
         end
      end
      return -1;
   endfunction

   // Flush a partial group, run the eight zero rounds and add the final one.
   function automatic logic [39:0] close_text(input logic [39:0] poly, input logic [4:0] group,
                                              input logic [1:0] count);
      logic [39:0] acc;
      acc = poly;
      if (count != 2'd0) begin
         acc = mix_symbol(acc, group);
      end
      for (int k = 0; k < 8; k++) begin
         acc = mix_symbol(acc, 5'd0);
      end
      return acc ^ 40'd1;
   endfunction

   // Spell eight symbols as checksum characters, first one in the top byte.
   function automatic logic [63:0] spell_checksum(input logic [39:0] sums);
      logic [63:0] chars;
      logic [4:0]  sym;
      chars = '0;
      for (int k = 0; k < 8; k++) begin
         sym = sums[5*(7-k) +: 5];
         chars[8*(7-k) +: 8] = CHECK_ALPHABET[8*(31-sym) +: 8];
      end
      return chars;
   endfunction

   // The characters a finish word would have to carry to match right now.
   assign current_chars = spell_checksum(close_text(text_poly, text_group, text_count));

   always @(posedge clock) begin : watch
      verdict_type want;
      int          pos;
      logic [6:0]  pos7;
      if (reset) begin
         text_poly      = 40'd1;
         text_group     = 5'd0;
         text_count     = 2'd0;
         text_bad       = 1'b0;
         pending_verdicts.delete();
         results_owed   = 0;
         fail_count     = 0;
         checksums_seen = 0;
         matches_seen   = 0;
         bad_seen       = 0;
      end else begin
         // Compare an accepted response word with the oldest verdict.
         if (rsp_valid && rsp_ready) begin
            checksums_seen++;
            if (rsp_checksum_matches) matches_seen++;
            if (rsp_bad_character) bad_seen++;
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected response word, symbols %h", $time,
                        rsp_checksum_symbols);
               fail_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_checksum_symbols !== want.symbols) begin
                  $display("%0t: checksum_symbols expected %h actual %h", $time,
                           want.symbols, rsp_checksum_symbols);
                  fail_count++;
               end
               if (rsp_bad_character !== want.bad) begin
                  $display("%0t: bad_character expected %b actual %b", $time,
                           want.bad, rsp_bad_character);
                  fail_count++;
               end
               if (rsp_checksum_matches !== want.ok) begin
                  $display("%0t: checksum_matches expected %b actual %b", $time,
                           want.ok, rsp_checksum_matches);
                  fail_count++;
               end
            end
         end

         // Follow the text stream, or close it on a finish word.
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_FEED) begin
               pos = charset_index(req_text_byte);
               if (pos < 0) begin
                  text_bad = 1'b1;
               end else begin
                  pos7       = pos[6:0];
                  text_poly  = mix_symbol(text_poly, pos7[4:0]);
                  text_group = text_group * 5'd3 + {3'b000, pos7[6:5]};
                  text_count = text_count + 2'd1;
                  if (text_count == 2'd3) begin
                     text_poly  = mix_symbol(text_poly, text_group);
                     text_group = 5'd0;
                     text_count = 2'd0;
                  end
               end
            end else begin
               want.symbols = close_text(text_poly, text_group, text_count);
               want.bad     = text_bad;
               want.ok      = !text_bad && (req_expected == spell_checksum(want.symbols));
               pending_verdicts.push_back(want);
               text_poly  = 40'd1;
               text_group = 5'd0;
               text_count = 2'd0;
               text_bad   = 1'b0;
            end
         end
         results_owed = pending_verdicts.size();
      end
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor checksum checker testbench
// Streams descriptor texts into the checker, each closed by a finish word that
// carries the right checksum, a checksum with one bit wrong, or given bits.
// A directed opening covers the empty text, bad bytes, both charset ends and
// partial groups; random texts with stalls on both channels follow. The
// monitor beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb
   import dcc_pkg::*;
();

   typedef enum {CHECK_RIGHT, CHECK_FLIPPED, CHECK_GIVEN} check_mode_type;

   logic        clock;
   logic        reset;
   logic        calm;
   logic [63:0] current_chars;
   int          results_owed;
   int          fail_count;
   int          checksums_seen;
   int          matches_seen;
   int          bad_seen;
   int          words_sent;

   dcc_req_if req_chan ();
   dcc_rsp_if rsp_chan ();

   descriptor_checksum_checker_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dcc_checksum_monitor u_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_chan.valid),
      .req_ready            (req_chan.ready),
      .req_cmd              (req_chan.cmd),
      .req_text_byte        (req_chan.text_byte),
      .req_expected         (req_chan.expected_checksum),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_checksum_symbols (rsp_chan.checksum_symbols),
      .rsp_bad_character    (rsp_chan.bad_character),
      .rsp_checksum_matches (rsp_chan.checksum_matches),
      .current_chars        (current_chars),
      .results_owed         (results_owed),
      .fail_count           (fail_count),
      .checksums_seen       (checksums_seen),
      .matches_seen         (matches_seen),
      .bad_seen             (bad_seen)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Response side: stall on about ten percent of cycles unless in the calm stretch.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 10);
      end
   end

   // Hard limit on the run.
   initial begin
      #4_800_000;
      $display("tb: FAIL");
      $finish;
   end

   // Offer one word from a falling edge and return at the falling edge after
   // it was taken.
   task automatic send_word(input logic c, input logic [7:0] b, input logic [63:0] e);
      while (!calm && $urandom_range(0, 99) < 10) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.cmd               <= c;
      req_chan.text_byte         <= b;
      req_chan.expected_checksum <= e;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // A text byte, with junk in the unused checksum field.
   task automatic feed(input logic [7:0] b);
      send_word(CMD_FEED, b, {$urandom, $urandom});
   endtask

   task automatic feed_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         feed(s[i]);
      end
   endtask

   // Close the text; the right characters come from the monitor's state.
   task automatic finish(input check_mode_type mode, input logic [63:0] given);
      logic [63:0] e;
      case (mode)
         CHECK_RIGHT:   e = current_chars;
         CHECK_FLIPPED: e = current_chars ^ (64'd1 << $urandom_range(0, 63));
         default:       e = given;
      endcase
      send_word(CMD_FINISH, 8'($urandom_range(0, 255)), e);
   endtask

   // Hold the sender, with the request channel idle, until every response
   // word is back.
   task automatic wait_drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int len;
      int pick;
      bit noisy;
      reset                      = 1'b1;
      calm                       = 1'b0;
      words_sent                 = 0;
      req_chan.valid             = 1'b0;
      req_chan.cmd               = CMD_FEED;
      req_chan.text_byte         = '0;
      req_chan.expected_checksum = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty text, bad bytes, charset ends and partial groups.
      finish(CHECK_RIGHT, '0);
      feed(8'h00);
      feed(8'hff);
      finish(CHECK_RIGHT, '0);
      feed_text("0~i ");
      feed(8'h60);
      finish(CHECK_RIGHT, '0);
      wait_drain();
      feed_text("abc");
      finish(CHECK_GIVEN, '1);
      send_word(CMD_FEED, "x", '1);
      finish(CHECK_GIVEN, '0);
      feed_text("wpkh(\\\"#");
      finish(CHECK_FLIPPED, '0);

      // Random texts, mostly clean and short, some noisy, a few long.
      while (words_sent < 920) begin
         calm  = (words_sent > 400 && words_sent < 560);
         len   = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 90)
                                              : $urandom_range(0, 20);
         noisy = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 5) == 0) begin
               feed(8'($urandom_range(0, 255)));
            end else begin
               feed(8'($urandom_range(32, 126)));
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            finish(CHECK_RIGHT, '0);
         end else if (pick < 85) begin
            finish(CHECK_FLIPPED, '0);
         end else begin
            finish(CHECK_GIVEN, {$urandom, $urandom});
         end
         if ($urandom_range(0, 7) == 0) begin
            wait_drain();
         end
      end
      calm = 1'b0;

      // Let the last response words come back, then wait quietly before the summary.
      wait_drain();
      repeat (10) @(negedge clock);
      $display("tb: %0d words sent, %0d checksums compared", words_sent, checksums_seen);
      $display("tb: %0d reported a match, %0d flagged a bad character",
               matches_seen, bad_seen);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
